@@ src/stts_pkg.sv @@
// Shared types, constants and keyword table for the structured text token scanner.
`default_nettype none

package stts_pkg;

    localparam int POS_BITS      = 16;
    localparam int START_BITS    = 16;
    localparam int LEN_BITS      = 16;
    localparam int KIND_BITS     = 3;
    localparam int KW_COUNT      = 7;
    localparam int KW_INDEX_BITS = 3;
    localparam int KW_MAX_LEN    = 11;
    localparam int KW_TEXT_BITS  = KW_MAX_LEN * 8;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = 2;
    localparam int Q_COUNT_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_LINE    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_BLOCK   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_OP      = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_SPECIAL = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_KEYWORD = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_UNTERM  = 3'd7;

    // Keyword text is right-justified: the first character sits in the highest used byte.
    localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        "PROGRAM", "VAR", "END_VAR", {"END_", "PROGRAM"}, "BOOL", "TRUE", "FALSE"
    };
    localparam int KW_LEN [KW_COUNT] = '{7, 3, 7, 11, 4, 4, 5};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_HELD,
        MODE_WORD,
        MODE_LINE,
        MODE_BLOCK
    } mode_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } char_word_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]     token_kind;
        logic [KW_INDEX_BITS-1:0] keyword_index;
        logic [START_BITS-1:0]    token_start;
        logic [LEN_BITS-1:0]      token_length;
        logic                     last_result;
    } token_word_t;

    typedef struct packed {
        logic [1:0]  count;
        token_word_t first;
        token_word_t second;
    } push_t;

    // Keywords that have character c at offset idx.
    function automatic logic [KW_COUNT-1:0] kw_match(input logic [7:0] c,
                                                     input logic [LEN_BITS-1:0] idx);
        logic [KW_COUNT-1:0] keep;
        int cp;
        keep = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (idx < LEN_BITS'(KW_LEN[k])) begin
                cp = KW_LEN[k] - 1 - int'(idx[3:0]);
                if (KW_TEXT[k][8*cp +: 8] == c) begin
                    keep[k] = 1'b1;
                end
            end
        end
        return keep;
    endfunction

endpackage

`default_nettype wire

@@ src/stts_core.sv @@
// Scanner state and per-byte token decision, producing up to two tokens per byte.
`default_nettype none

module stts_core
    import stts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire char_word_t char_word,
    output push_t           push
);

    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_EQUAL  = "=";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);

    mode_t                     mode_reg, mode_mid, mode_next;
    logic [7:0]                held_reg, held_mid, held_next;
    logic                      star_reg, star_mid, star_next;
    logic [POS_BITS-1:0]       pos_reg, pos_next;
    logic [POS_BITS-1:0]       start_reg, start_mid, start_next;
    logic [LEN_BITS-1:0]       len_reg, len_mid, len_next;
    logic [KW_COUNT-1:0]       kw_reg, kw_mid, kw_next;

    logic [7:0]                c;
    logic                      used;
    logic                      is_space, is_letter, is_word_char, is_op, is_special, is_hold;
    logic [LEN_BITS-1:0]       len_inc;
    logic                      va, vb, vc;
    token_word_t               tok_a, tok_b, tok_c;
    logic [1:0]                n_tok;

    function automatic token_word_t make_tok(input logic [KIND_BITS-1:0] kind,
                                             input logic [KW_INDEX_BITS-1:0] kw,
                                             input logic [POS_BITS-1:0] start,
                                             input logic [LEN_BITS-1:0] len);
        token_word_t t;
        t.token_kind    = kind;
        t.keyword_index = kw;
        t.token_start   = START_BITS'(start);
        t.token_length  = len;
        t.last_result   = 1'b0;
        return t;
    endfunction

    // A still-matching keyword whose length equals the word length is an exact match.
    function automatic token_word_t word_tok(input logic [KW_COUNT-1:0] kw,
                                             input logic [LEN_BITS-1:0] len,
                                             input logic [POS_BITS-1:0] start);
        token_word_t t;
        logic found;
        t = make_tok(KIND_IDENT, '0, start, len);
        found = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && kw[k] && len == LEN_BITS'(KW_LEN[k])) begin
                found = 1'b1;
                t = make_tok(KIND_KEYWORD, KW_INDEX_BITS'(k), start, len);
            end
        end
        return t;
    endfunction

    function automatic logic [KIND_BITS-1:0] held_kind(input logic [7:0] h);
        return (h == CH_COLON) ? KIND_SPECIAL : KIND_UNKNOWN;
    endfunction

    assign c            = char_word.character;
    assign is_space     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_letter    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_word_char = is_letter || (c >= "0" && c <= "9") || (c == CH_UNDER);
    assign is_op        = (c == CH_GT) || (c == CH_LT) || (c == CH_PLUS) || (c == CH_MINUS);
    assign is_special   = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK)
                          || (c == CH_RBRACK) || (c == CH_SEMI);
    assign is_hold      = (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_COLON)
                          || (c == CH_EQUAL);
    assign len_inc      = (len_reg == '1) ? len_reg : len_reg + LEN_ONE;

    // The byte is consumed by the open token unless that token ends before it.
    always_comb
    begin
        case (mode_reg)
            MODE_HELD:  used = ((held_reg == CH_SLASH) && (c == CH_SLASH))
                               || ((held_reg == CH_LPAREN) && (c == CH_STAR))
                               || ((held_reg == CH_COLON) && (c == CH_EQUAL))
                               || ((held_reg == CH_EQUAL) && (c == CH_GT));
            MODE_WORD:  used = is_word_char;
            MODE_LINE:  used = 1'b1;
            MODE_BLOCK: used = 1'b1;
            default:    used = 1'b0;
        endcase
    end

    // Next state: the open token first, then a token started by this byte.
    always_comb
    begin
        mode_mid  = MODE_IDLE;
        held_mid  = held_reg;
        star_mid  = star_reg;
        start_mid = start_reg;
        len_mid   = len_reg;
        kw_mid    = kw_reg;
        case (mode_reg)
            MODE_HELD:
            begin
                if (held_reg == CH_SLASH && c == CH_SLASH) begin
                    mode_mid = MODE_LINE;
                    len_mid  = LEN_TWO;
                end else if (held_reg == CH_LPAREN && c == CH_STAR) begin
                    mode_mid = MODE_BLOCK;
                    len_mid  = LEN_TWO;
                    star_mid = 1'b0;
                end
            end
            MODE_WORD:
            begin
                if (is_word_char) begin
                    mode_mid = MODE_WORD;
                    kw_mid   = kw_reg & kw_match(c, len_reg);
                    len_mid  = len_inc;
                end
            end
            MODE_LINE:
            begin
                if (c != CH_LF) begin
                    mode_mid = MODE_LINE;
                    len_mid  = len_inc;
                end
            end
            MODE_BLOCK:
            begin
                len_mid = len_inc;
                if (star_reg && c == CH_RPAREN) begin
                    star_mid = 1'b0;
                end else begin
                    mode_mid = MODE_BLOCK;
                    star_mid = (c == CH_STAR);
                end
            end
            default:
            begin
                mode_mid = MODE_IDLE;
            end
        endcase
        if (!used) begin
            if (is_hold) begin
                mode_mid  = MODE_HELD;
                held_mid  = c;
                start_mid = pos_reg;
            end else if (is_letter) begin
                mode_mid  = MODE_WORD;
                start_mid = pos_reg;
                kw_mid    = kw_match(c, '0);
                len_mid   = LEN_ONE;
            end
        end
    end

    // End of input flushes everything back to the reset state.
    always_comb
    begin
        if (char_word.end_of_input) begin
            mode_next  = MODE_IDLE;
            held_next  = '0;
            star_next  = 1'b0;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            kw_next    = '1;
        end else begin
            mode_next  = mode_mid;
            held_next  = held_mid;
            star_next  = star_mid;
            pos_next   = pos_reg + POS_BITS'(1);
            start_next = start_mid;
            len_next   = len_mid;
            kw_next    = kw_mid;
        end
    end

    // Outputs: token closed by this byte, token formed by this byte alone, flushed token.
    always_comb
    begin
        va    = 1'b0;
        vb    = 1'b0;
        vc    = 1'b0;
        tok_a = make_tok(KIND_UNKNOWN, '0, start_reg, LEN_ONE);
        tok_b = make_tok(KIND_UNKNOWN, '0, pos_reg, LEN_ONE);
        tok_c = make_tok(KIND_UNTERM, '0, start_mid, len_mid);
        case (mode_reg)
            MODE_HELD:
            begin
                if (((held_reg == CH_COLON) && (c == CH_EQUAL))
                    || ((held_reg == CH_EQUAL) && (c == CH_GT))) begin
                    va    = 1'b1;
                    tok_a = make_tok(KIND_OP, '0, start_reg, LEN_TWO);
                end else if (!used) begin
                    va    = 1'b1;
                    tok_a = make_tok(held_kind(held_reg), '0, start_reg, LEN_ONE);
                end
            end
            MODE_WORD:
            begin
                if (!is_word_char) begin
                    va    = 1'b1;
                    tok_a = word_tok(kw_reg, len_reg, start_reg);
                end
            end
            MODE_LINE:
            begin
                if (c == CH_LF) begin
                    va    = 1'b1;
                    tok_a = make_tok(KIND_LINE, '0, start_reg, len_reg);
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && c == CH_RPAREN) begin
                    va    = 1'b1;
                    tok_a = make_tok(KIND_BLOCK, '0, start_reg, len_inc);
                end
            end
            default:
            begin
                va = 1'b0;
            end
        endcase
        if (!used && !is_space && !is_hold && !is_letter) begin
            vb = 1'b1;
            if (is_op) begin
                tok_b = make_tok(KIND_OP, '0, pos_reg, LEN_ONE);
            end else if (is_special) begin
                tok_b = make_tok(KIND_SPECIAL, '0, pos_reg, LEN_ONE);
            end
        end
        if (char_word.end_of_input) begin
            case (mode_mid)
                MODE_HELD:
                begin
                    vc    = 1'b1;
                    tok_c = make_tok(held_kind(held_mid), '0, start_mid, LEN_ONE);
                end
                MODE_WORD:
                begin
                    vc    = 1'b1;
                    tok_c = word_tok(kw_mid, len_mid, start_mid);
                end
                MODE_LINE, MODE_BLOCK:
                begin
                    vc = 1'b1;
                end
                default:
                begin
                    vc = 1'b0;
                end
            endcase
        end
    end

    // At most two of the three candidates are ever present; pack them in order.
    always_comb
    begin
        n_tok        = {1'b0, va} + {1'b0, vb} + {1'b0, vc};
        push.count   = accept ? n_tok : 2'd0;
        push.first   = va ? tok_a : (vb ? tok_b : tok_c);
        push.second  = (va && vb) ? tok_b : tok_c;
        push.first.last_result  = (n_tok == 2'd1);
        push.second.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            held_reg  <= '0;
            star_reg  <= 1'b0;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            kw_reg    <= '1;
        end else if (accept) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            star_reg  <= star_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
        end
    end

endmodule

`default_nettype wire

@@ src/stts_out_queue.sv @@
// Small result queue that takes up to two token words a cycle and hands out one unless token_stall is set.
`default_nettype none

module stts_out_queue
    import stts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire push_t       push,
    output logic             room,
    output logic             token_valid,
    input  wire logic        token_stall,
    output token_word_t      token_word
);

    token_word_t               mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_COUNT_BITS-1:0]   count_reg, count_next;
    logic                      pop;

    // Room is judged on the registered count so that it never waits on the output side.
    assign room        = (count_reg <= Q_COUNT_BITS'(Q_DEPTH - 2));
    assign token_valid = (count_reg != '0);
    assign token_word  = mem[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_BITS'(pop);
        count_next  = count_reg + Q_COUNT_BITS'(push.count) - Q_COUNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + Q_PTR_BITS'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/structured_text_token_scanner.sv @@
// Top level of the structured text token scanner.
//
// Source bytes arrive on the char channel (char_valid, char_stall, char_word),
// one byte per word, with end_of_input set on the last byte of a text. Tokens
// leave on the token channel (token_valid, token_stall, token_word), one token
// per word, each giving kind, keyword index, start offset and length; the last
// token caused by a byte carries last_result.
// A byte is scanned in the cycle it is accepted and its tokens are written to a
// four-entry result queue, from which they leave on the token channel. The
// scanner accepts one byte every cycle while the queue has room for two tokens;
// a byte that closes one token and forms another writes both, which leave in turn.
// When the receiver stalls, the queue fills and char_stall rises once fewer than
// two entries are free; the token on the port holds until taken.
// Reset clears the scan state, the byte offset and the queue; after a byte with
// end_of_input the scan state and offset reset and the next byte is offset 0.
`default_nettype none

module structured_text_token_scanner
    import stts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire char_word_t  char_word,
    output logic             token_valid,
    input  wire logic        token_stall,
    output token_word_t      token_word
);

    push_t push;
    logic  room;
    logic  accept;

    assign char_stall = !room;
    assign accept     = char_valid && room;

    stts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_word (char_word),
        .push      (push)
    );

    stts_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the structured text token scanner.
module tb_top;
    import stts_pkg::*;

    typedef struct packed {
        logic       drain;
        char_word_t w;
    } pending_t;

    localparam int NUM_KEYWORDS = 7;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    char_word_t  char_word = '0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    token_word_t token_word;

    string kw_names[NUM_KEYWORDS] = '{"PROGRAM", "VAR", "END_VAR", {"END_", "PROGRAM"},
                                      "BOOL", "TRUE", "FALSE"};
    string op_names[6] = '{">", "<", "+", "-", ":=", "=>"};
    string special_chars = "{}[];:";

    // Scanner state as predicted by the testbench.
    mode_t       scan_state = MODE_IDLE;
    logic [7:0]  held_byte = '0;
    logic        star_seen = 1'b0;
    logic [15:0] offset = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_len = '0;
    logic [6:0]  kw_alive = '1;

    token_word_t step_tokens[$];
    token_word_t expected_tokens[$];
    pending_t    pending_chars[$];
    pending_t    next_char;
    logic [7:0]  text_buf[$];

    int  chars_taken = 0;
    int  mismatch_count = 0;
    int  random_bytes = 0;
    wire quiet = (chars_taken >= 200) && (chars_taken < 350);

    structured_text_token_scanner uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_ws(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word_byte(logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic add_token(logic [2:0] kind, logic [2:0] kw, logic [15:0] start,
                             logic [15:0] len);
        token_word_t t;
        t.token_kind    = kind;
        t.keyword_index = kw;
        t.token_start   = start;
        t.token_length  = len;
        t.last_result   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic narrow_keywords(logic [7:0] c, logic [15:0] idx);
        logic [6:0] keep;
        keep = '0;
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            if (idx < kw_names[k].len() && kw_names[k][int'(idx)] == c)
                keep[k] = 1'b1;
        end
        kw_alive &= keep;
    endtask

    task automatic close_word();
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            if (kw_alive[k] && tok_len == kw_names[k].len())
            begin
                add_token(KIND_KEYWORD, 3'(k), tok_start, tok_len);
                return;
            end
        end
        add_token(KIND_IDENT, 3'd0, tok_start, tok_len);
    endtask

    task automatic close_held();
        add_token((held_byte == ":") ? KIND_SPECIAL : KIND_UNKNOWN, 3'd0, tok_start, 16'd1);
    endtask

    task automatic clear_scan();
        scan_state = MODE_IDLE;
        held_byte  = '0;
        star_seen  = 1'b0;
        offset     = '0;
        tok_start  = '0;
        tok_len    = '0;
        kw_alive   = '1;
    endtask

    task automatic begin_token(logic [7:0] c, logic [15:0] pos);
        scan_state = MODE_IDLE;
        if (is_ws(c))
            return;
        if (c == ">" || c == "<" || c == "+" || c == "-")
            add_token(KIND_OP, 3'd0, pos, 16'd1);
        else if (c == "{" || c == "}" || c == "[" || c == "]" || c == ";")
            add_token(KIND_SPECIAL, 3'd0, pos, 16'd1);
        else if (c == "/" || c == "(" || c == ":" || c == "=")
        begin
            scan_state = MODE_HELD;
            held_byte  = c;
            tok_start  = pos;
        end
        else if (is_alpha(c))
        begin
            scan_state = MODE_WORD;
            tok_start  = pos;
            kw_alive   = '1;
            narrow_keywords(c, 16'd0);
            tok_len    = 16'd1;
        end
        else
            add_token(KIND_UNKNOWN, 3'd0, pos, 16'd1);
    endtask

    // Works out the tokens that one accepted word causes and queues them.
    task automatic predict_tokens(char_word_t w);
        logic [7:0]  c;
        logic [15:0] pos;
        logic        taken;
        token_word_t t;
        c     = w.character;
        pos   = offset;
        taken = 1'b0;
        step_tokens.delete();
        case (scan_state)
            MODE_HELD:
            begin
                if (held_byte == "/" && c == "/")
                begin
                    scan_state = MODE_LINE;
                    tok_len    = 16'd2;
                    taken      = 1'b1;
                end
                else if (held_byte == "(" && c == "*")
                begin
                    scan_state = MODE_BLOCK;
                    tok_len    = 16'd2;
                    star_seen  = 1'b0;
                    taken      = 1'b1;
                end
                else if ((held_byte == ":" && c == "=") || (held_byte == "=" && c == ">"))
                begin
                    add_token(KIND_OP, 3'd0, tok_start, 16'd2);
                    scan_state = MODE_IDLE;
                    taken      = 1'b1;
                end
                else
                begin
                    close_held();
                    scan_state = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (is_word_byte(c))
                begin
                    narrow_keywords(c, tok_len);
                    tok_len = sat_inc(tok_len);
                    taken   = 1'b1;
                end
                else
                begin
                    close_word();
                    scan_state = MODE_IDLE;
                end
            end
            MODE_LINE:
            begin
                if (c == 8'h0A)
                begin
                    add_token(KIND_LINE, 3'd0, tok_start, tok_len);
                    scan_state = MODE_IDLE;
                end
                else
                    tok_len = sat_inc(tok_len);
                taken = 1'b1;
            end
            MODE_BLOCK:
            begin
                tok_len = sat_inc(tok_len);
                if (star_seen && c == ")")
                begin
                    add_token(KIND_BLOCK, 3'd0, tok_start, tok_len);
                    scan_state = MODE_IDLE;
                    star_seen  = 1'b0;
                end
                else
                    star_seen = (c == "*");
                taken = 1'b1;
            end
            default:
                scan_state = MODE_IDLE;
        endcase

        if (!taken)
            begin_token(c, pos);

        if (w.end_of_input)
        begin
            case (scan_state)
                MODE_HELD:              close_held();
                MODE_WORD:              close_word();
                MODE_LINE, MODE_BLOCK:  add_token(KIND_UNTERM, 3'd0, tok_start, tok_len);
                default:                ;
            endcase
            clear_scan();
        end
        else
            offset = pos + 16'd1;

        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t = step_tokens[i];
            t.last_result = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_token(token_word_t got);
        token_word_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("token with none expected: kind %0d start %0d len %0d",
                                      got.token_kind, got.token_start, got.token_length));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
            report_mismatch($sformatf("token_kind %0d, expected %0d",
                                      got.token_kind, want.token_kind));
        if (got.keyword_index !== want.keyword_index)
            report_mismatch($sformatf("keyword_index %0d, expected %0d",
                                      got.keyword_index, want.keyword_index));
        if (got.token_start !== want.token_start)
            report_mismatch($sformatf("token_start %0d, expected %0d",
                                      got.token_start, want.token_start));
        if (got.token_length !== want.token_length)
            report_mismatch($sformatf("token_length %0d, expected %0d",
                                      got.token_length, want.token_length));
        if (got.last_result !== want.last_result)
            report_mismatch($sformatf("last_result %0d, expected %0d",
                                      got.last_result, want.last_result));
    endtask

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge clk)
    begin
        if (!rst_n)
            char_valid <= 1'b0;
        else
        begin
            if (char_valid && !char_stall)
            begin
                predict_tokens(char_word);
                chars_taken <= chars_taken + 1;
            end
            if (!char_valid || !char_stall)
            begin
                // A word marked drain waits until every queued token has come out.
                if (pending_chars.size() != 0 && !(!quiet && $urandom_range(99) < 7)
                    && !(pending_chars[0].drain && expected_tokens.size() != 0))
                begin
                    next_char = pending_chars.pop_front();
                    char_valid <= 1'b1;
                    char_word  <= next_char.w;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
            check_token(token_word);
        token_stall <= rst_n && !quiet && ($urandom_range(99) < 7);
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_byte(logic [7:0] b);
        text_buf.push_back(b);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Queues the text buffer as one text, end_of_input on its last byte.
    task automatic send_text(bit drain);
        pending_t p;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            p.drain            = drain && (i == 0);
            p.w.character      = text_buf[i];
            p.w.end_of_input   = (i == text_buf.size() - 1);
            pending_chars.push_back(p);
        end
        text_buf.delete();
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(25)) + ($urandom_range(1) ? "A" : "a");
    endfunction

    function automatic logic [7:0] rand_word_byte();
        int unsigned r;
        r = $urandom_range(63);
        if (r < 52)
            return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return "_";
    endfunction

    task automatic add_ws();
        int unsigned r;
        r = $urandom_range(5);
        add_byte((r == 5) ? 8'h20 : 8'(9 + r));
    endtask

    task automatic add_fragment();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        string       s;
        pick = $urandom_range(12);
        case (pick)
            0, 1:
                add_str(kw_names[$urandom_range(NUM_KEYWORDS - 1)]);
            2:
            begin
                k = $urandom_range(NUM_KEYWORDS - 1);
                s = kw_names[k];
                case ($urandom_range(2))
                    0: add_str(s.substr(0, s.len() - 2));
                    1:
                    begin
                        add_str(s);
                        add_byte(rand_word_byte());
                    end
                    default:
                    begin
                        add_byte(s[0] ^ 8'h20);
                        add_str(s.substr(1, s.len() - 1));
                    end
                endcase
            end
            3:
            begin
                add_byte(rand_letter());
                n = $urandom_range(8);
                repeat (n) add_byte(rand_word_byte());
            end
            4:
                add_str(op_names[$urandom_range(5)]);
            5:
                add_byte(special_chars[$urandom_range(5)]);
            6:
            begin
                add_str("//");
                n = $urandom_range(10);
                repeat (n) add_byte(8'($urandom_range(32, 126)));
                if ($urandom_range(9) < 8)
                    add_byte(8'h0A);
            end
            7:
            begin
                add_str("(*");
                n = $urandom_range(10);
                s = "a*)( \n";
                repeat (n) add_byte(s[$urandom_range(5)]);
                if ($urandom_range(9) < 8)
                    add_str("*)");
            end
            8:
            begin
                s = "/(=:";
                add_byte(s[$urandom_range(3)]);
            end
            9:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'($urandom_range(255)));
            end
            10:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_ws();
            end
            default:
                add_byte(8'($urandom_range(33, 126)));
        endcase
    endtask

    initial
    begin
        int unsigned frags;

        // Directed texts: lookahead pairs, lone lookahead bytes, a comment
        // that "(*)" must not close, an open line comment at end of text,
        // every single-byte token, and the byte extremes.
        add_str("(*)*)");
        send_text(1'b0);
        add_str("//a");
        send_text(1'b0);
        add_str("/x(=:");
        send_text(1'b0);
        add_str("{}[];+-<>");
        send_text(1'b0);
        add_str("A:=b=>");
        send_text(1'b0);
        add_byte(8'h00);
        add_byte(8'h7F);
        add_byte(8'h80);
        add_byte(8'hFF);
        send_text(1'b0);
        add_str("Q");
        send_text(1'b0);

        // Random texts built mostly from well-formed tokens.
        while (random_bytes < 420)
        begin
            frags = $urandom_range(1, 12);
            repeat (frags)
            begin
                add_fragment();
                if ($urandom_range(1))
                    add_ws();
            end
            random_bytes += text_buf.size();
            send_text(random_bytes == text_buf.size());
        end

        while (pending_chars.size() != 0 || char_valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
